// File: hw/rtl/wsfp_pkg.sv
// Package for the WebSocket frame parser: parser phases, result kinds,
// the queue entry passed from the front end to the back end, and constants.
// No dependencies.
`default_nettype none

package wsfp_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [2:0] MaskKeyBytes = 3'd4;
  localparam logic [6:0] LenCode16    = 7'd126;
  localparam logic [6:0] LenCode64    = 7'd127;

  typedef enum logic [2:0] {
    PH_B0   = 3'd0,
    PH_B1   = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  key;
    logic [3:0]  opcode;
    logic        fin;
    logic [2:0]  rsv;
    logic        masked;
    logic [62:0] len;
    logic        frame_end;
  } wsfp_entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/wsfp_if.sv
// Stream interfaces of the WebSocket frame parser: the byte input channel
// and the result channel. Valid/ready handshake; no dependencies.
`default_nettype none

interface ws_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface ws_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [3:0]  opcode;
  logic        final_frame;
  logic [2:0]  reserved_bits;
  logic        is_masked;
  logic [62:0] frame_length;
  logic        frame_end;

  modport source (
    output valid, output kind, output payload_byte, output opcode,
    output final_frame, output reserved_bits, output is_masked,
    output frame_length, output frame_end, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input opcode,
    input final_frame, input reserved_bits, input is_masked,
    input frame_length, input frame_end, output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/wsfp_front.sv
// Front end of the WebSocket frame parser: header state machine that takes
// one byte per beat and emits at most one queue entry per byte.
// Depends on wsfp_pkg.
`default_nettype none

module wsfp_front
  import wsfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  byte_i,
  output wsfp_entry_t      entry_o,
  output logic             push_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [4:0]  flags_q, flags_d;
  logic [63:0] len_q, len_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] key_q, key_d;
  logic [62:0] remain_q, remain_d;
  logic [1:0]  midx_q, midx_d;

  logic [6:0]  code;
  logic        code_ext;
  logic [2:0]  cnt_dec;
  logic [63:0] len_shift;
  logic [62:0] remain_dec;
  logic        cnt_last;
  logic        err_ext;
  logic        err_b0;
  logic        hdr_done;
  logic [63:0] hdr_len;
  logic [7:0]  key_byte;

  always_comb begin
    code       = byte_i[6:0];
    code_ext   = (code == LenCode16) || (code == LenCode64);
    cnt_dec    = cnt_q - 3'd1;
    cnt_last   = (cnt_dec == 3'd0);
    len_shift  = {len_q[55:0], byte_i};
    remain_dec = remain_q - 63'd1;
    err_b0     = byte_i[3] && !byte_i[7];
    err_ext    = 1'b0;
    hdr_done   = 1'b0;
    hdr_len    = len_q;
    case (phase_q)
      PH_B1: begin
        hdr_done = !code_ext && !byte_i[7];
        hdr_len  = {57'd0, code};
      end
      PH_EXT: begin
        err_ext  = cnt_last && len_shift[63];
        hdr_done = cnt_last && !len_shift[63] && !flags_q[0];
        hdr_len  = len_shift;
      end
      PH_KEY: begin
        hdr_done = cnt_last;
        hdr_len  = len_q;
      end
      default: begin
        hdr_done = 1'b0;
      end
    endcase
    case (midx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      case (phase_q)
        PH_B1: begin
          if (code_ext) begin
            phase_d = PH_EXT;
          end else if (byte_i[7]) begin
            phase_d = PH_KEY;
          end
        end
        PH_EXT: begin
          if (err_ext) begin
            phase_d = PH_B0;
          end else if (cnt_last) begin
            phase_d = PH_KEY;
          end
        end
        PH_KEY: begin
          phase_d = PH_KEY;
        end
        PH_DATA: begin
          if (remain_dec == 63'd0) begin
            phase_d = PH_B0;
          end
        end
        default: begin
          phase_d = err_b0 ? PH_B0 : PH_B1;
        end
      endcase
      if (hdr_done) begin
        phase_d = (hdr_len == 64'd0) ? PH_B0 : PH_DATA;
      end
    end
  end

  always_comb begin
    opcode_d = opcode_q;
    flags_d  = flags_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    remain_d = remain_q;
    midx_d   = midx_q;
    push_o   = 1'b0;
    entry_o  = '0;
    if (accept_i) begin
      case (phase_q)
        PH_B1: begin
          flags_d = {flags_q[4:1], byte_i[7]};
          key_d   = 32'd0;
          len_d   = code_ext ? 64'd0 : {57'd0, code};
          if (code == LenCode16) begin
            cnt_d = 3'd2;
          end else if (code == LenCode64) begin
            cnt_d = 3'd0;
          end else if (byte_i[7]) begin
            cnt_d = MaskKeyBytes;
          end
        end
        PH_EXT: begin
          len_d = len_shift;
          cnt_d = (cnt_last && flags_q[0] && !len_shift[63]) ? MaskKeyBytes : cnt_dec;
        end
        PH_KEY: begin
          key_d = {key_q[23:0], byte_i};
          cnt_d = cnt_dec;
        end
        PH_DATA: begin
          midx_d   = midx_q + 2'd1;
          remain_d = remain_dec;
        end
        default: begin
          opcode_d = byte_i[3:0];
          flags_d  = {byte_i[7], byte_i[6:4], 1'b0};
          len_d    = 64'd0;
          remain_d = 63'd0;
          key_d    = 32'd0;
          midx_d   = 2'd0;
          cnt_d    = 3'd0;
        end
      endcase
      if (hdr_done) begin
        remain_d = hdr_len[62:0];
        midx_d   = 2'd0;
      end

      entry_o.opcode = opcode_d;
      entry_o.fin    = flags_d[4];
      entry_o.rsv    = flags_d[3:1];
      entry_o.masked = flags_d[0];
      if (hdr_done) begin
        push_o            = 1'b1;
        entry_o.kind      = KIND_HEADER;
        entry_o.len       = hdr_len[62:0];
        entry_o.frame_end = (hdr_len == 64'd0);
      end else if (err_ext || ((phase_q != PH_B1) && (phase_q != PH_EXT) &&
                   (phase_q != PH_KEY) && (phase_q != PH_DATA) && err_b0)) begin
        push_o       = 1'b1;
        entry_o.kind = KIND_ERROR;
      end else if (phase_q == PH_DATA) begin
        push_o            = 1'b1;
        entry_o.kind      = KIND_PAYLOAD;
        entry_o.data      = byte_i;
        entry_o.key       = key_byte;
        entry_o.len       = len_q[62:0];
        entry_o.frame_end = (remain_dec == 63'd0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_B0;
      opcode_q <= '0;
      flags_q  <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      key_q    <= '0;
      remain_q <= '0;
      midx_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      flags_q  <= flags_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      key_q    <= key_d;
      remain_q <= remain_d;
      midx_q   <= midx_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/wsfp_queue.sv
// Short queue of parser entries between the front end and the back end.
// Depends on wsfp_pkg.
`default_nettype none

module wsfp_queue
  import wsfp_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wsfp_entry_t      entry_i,
  output logic             full_o,
  output logic             valid_o,
  output wsfp_entry_t      entry_o,
  input  wire logic        pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  wsfp_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  always_comb begin
    full_o  = (count_q == CntW'(Depth));
    valid_o = (count_q != '0);
    entry_o = mem_q[rd_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/wsfp_back.sv
// Back end of the WebSocket frame parser: unmasks payload bytes and holds
// each result in the output register until the sink takes the beat.
// Depends on wsfp_pkg.
`default_nettype none

module wsfp_back
  import wsfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wsfp_entry_t      q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output kind_e            kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [3:0]       opcode_o,
  output logic             final_frame_o,
  output logic [2:0]       reserved_bits_o,
  output logic             is_masked_o,
  output logic [62:0]      frame_length_o,
  output logic             frame_end_o
);

  logic        vld_q, vld_d;
  wsfp_entry_t res_q;
  logic [7:0]  byte_q;

  always_comb begin
    q_pop_o = q_valid_i && (!vld_q || out_ready_i);
    vld_d   = q_pop_o || (vld_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q  <= q_entry_i;
      byte_q <= q_entry_i.data ^ q_entry_i.key;
    end
  end

  assign out_valid_o     = vld_q;
  assign kind_o          = res_q.kind;
  assign payload_byte_o  = byte_q;
  assign opcode_o        = res_q.opcode;
  assign final_frame_o   = res_q.fin;
  assign reserved_bits_o = res_q.rsv;
  assign is_masked_o     = res_q.masked;
  assign frame_length_o  = res_q.len;
  assign frame_end_o     = res_q.frame_end;

endmodule

`default_nettype wire

// File: hw/rtl/websocket_frame_parser.sv
// Top level of the WebSocket frame parser: front end, entry queue, back end.
// Depends on wsfp_pkg, ws_byte_if, ws_res_if and the wsfp_* modules.
//
//   Channel  Dir  Beat content
//   byte_i   in   in_byte: one byte of the received stream
//   res_o    out  kind, payload_byte, opcode, final_frame, reserved_bits,
//                 is_masked, frame_length, frame_end
//
// One byte is accepted per cycle whenever the entry queue has room; each byte
// yields zero or one result. A result reaches res_o through a queue entry and
// then the output register.
// byte_i.ready drops only when the queue of QUEUE_DEPTH entries is full.
// The asynchronous reset returns the parser to byte zero and empties the queue.
`default_nettype none

module websocket_frame_parser
  import wsfp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ws_byte_if.sink     byte_i,
  ws_res_if.source    res_o
);

  wsfp_entry_t front_entry;
  wsfp_entry_t q_entry;
  logic        front_push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        accept;
  kind_e       kind;

  assign byte_i.ready = !q_full;
  assign accept       = byte_i.valid && !q_full;

  wsfp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (byte_i.in_byte),
    .entry_o  (front_entry),
    .push_o   (front_push)
  );

  wsfp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (q_pop)
  );

  wsfp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_entry),
    .q_pop_o         (q_pop),
    .out_valid_o     (res_o.valid),
    .out_ready_i     (res_o.ready),
    .kind_o          (kind),
    .payload_byte_o  (res_o.payload_byte),
    .opcode_o        (res_o.opcode),
    .final_frame_o   (res_o.final_frame),
    .reserved_bits_o (res_o.reserved_bits),
    .is_masked_o     (res_o.is_masked),
    .frame_length_o  (res_o.frame_length),
    .frame_end_o     (res_o.frame_end)
  );

  assign res_o.kind = kind;

endmodule

`default_nettype wire

// File: hw/rtl/wsfp_checker.sv
// Port-level checks for the WebSocket frame parser and their bind statement.
// Depends on wsfp_pkg and websocket_frame_parser.
`default_nettype none

module wsfp_checker
  import wsfp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_i,
  input wire logic [1:0]  kind_i,
  input wire logic [7:0]  payload_byte_i,
  input wire logic [62:0] frame_length_i,
  input wire logic        frame_end_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(kind_i) && $stable(payload_byte_i))
    else $error("Result changed while stalled.");

  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (kind_i != KIND_PAYLOAD) |-> payload_byte_i == 8'd0)
    else $error("Payload byte set on a non-payload result.");

  a_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (kind_i == KIND_ERROR) |-> (frame_length_i == '0) && !frame_end_i)
    else $error("Error result carries length or end mark.");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (kind_i == KIND_HEADER) |-> frame_end_i == (frame_length_i == '0))
    else $error("Header end mark does not match the frame length.");

endmodule

bind websocket_frame_parser wsfp_checker u_wsfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (res_o.valid),
  .ready_i        (res_o.ready),
  .kind_i         (res_o.kind),
  .payload_byte_i (res_o.payload_byte),
  .frame_length_i (res_o.frame_length),
  .frame_end_i    (res_o.frame_end)
);

`default_nettype wire

// File: tb/sv/websocket_frame_parser_tb.sv
// Self-checking testbench for websocket_frame_parser: drives WebSocket frames byte by byte
// and checks every result beat against a cycle-free model of the frame parser.
// Depends on wsfp_pkg, ws_byte_if, ws_res_if and the parser RTL.
`default_nettype none

module websocket_frame_parser_tb;
  import wsfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomBytes = 1300;
  localparam int unsigned StreamBytes = 300;
  localparam int unsigned ReportLimit = 50;

  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [3:0]  opcode;
    logic        final_frame;
    logic [2:0]  reserved_bits;
    logic        is_masked;
    logic [62:0] frame_length;
    logic        frame_end;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ws_byte_if byte_if ();
  ws_res_if  res_if ();

  websocket_frame_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .res_o  (res_if)
  );

  always #6 clk_i = ~clk_i;

  frame_result_t expected_results[$];
  int unsigned   mismatch_count = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   cycle_count = 0;
  bit            tx_idle_on = 1'b0;
  bit            rx_idle_on = 1'b0;
  int unsigned   rx_hold_cycles = 0;

  // Parser model state.
  phase_e      mdl_phase = PH_B0;
  logic [3:0]  mdl_opcode = '0;
  logic [4:0]  mdl_flags = '0;
  logic [63:0] mdl_length = '0;
  logic [2:0]  mdl_count = '0;
  logic [31:0] mdl_key = '0;
  logic [63:0] mdl_remaining = '0;
  logic [1:0]  mdl_key_index = '0;

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  function automatic void expect_result(input kind_e kind, input logic [7:0] data,
                                        input logic [63:0] len, input logic last);
    frame_result_t r;
    r.kind          = kind;
    r.payload_byte  = data;
    r.opcode        = mdl_opcode;
    r.final_frame   = mdl_flags[4];
    r.reserved_bits = mdl_flags[3:1];
    r.is_masked     = mdl_flags[0];
    r.frame_length  = len[62:0];
    r.frame_end     = last;
    expected_results.push_back(r);
  endfunction

  function automatic void finish_header();
    mdl_remaining = mdl_length;
    mdl_key_index = '0;
    if (mdl_length == 0) begin
      mdl_phase = PH_B0;
      expect_result(KIND_HEADER, 8'h00, mdl_length, 1'b1);
    end else begin
      mdl_phase = PH_DATA;
      expect_result(KIND_HEADER, 8'h00, mdl_length, 1'b0);
    end
  endfunction

  function automatic void predict_parse_step(input logic [7:0] b);
    logic [6:0] code;
    logic [7:0] key_byte;
    logic [7:0] data;
    case (mdl_phase)
      PH_B1: begin
        code = b[6:0];
        mdl_flags = {mdl_flags[4:1], b[7]};
        mdl_key = '0;
        mdl_length = '0;
        if (code == LenCode16) begin
          mdl_count = 3'd2;
          mdl_phase = PH_EXT;
        end else if (code == LenCode64) begin
          mdl_count = 3'd0;
          mdl_phase = PH_EXT;
        end else begin
          mdl_length = {57'd0, code};
          if (mdl_flags[0]) begin
            mdl_count = MaskKeyBytes;
            mdl_phase = PH_KEY;
          end else begin
            finish_header();
          end
        end
      end
      PH_EXT: begin
        mdl_length = {mdl_length[55:0], b};
        mdl_count = mdl_count - 3'd1;
        if (mdl_count == 0) begin
          if (mdl_length[63]) begin
            mdl_phase = PH_B0;
            expect_result(KIND_ERROR, 8'h00, 64'd0, 1'b0);
          end else if (mdl_flags[0]) begin
            mdl_count = MaskKeyBytes;
            mdl_phase = PH_KEY;
          end else begin
            finish_header();
          end
        end
      end
      PH_KEY: begin
        mdl_key = {mdl_key[23:0], b};
        mdl_count = mdl_count - 3'd1;
        if (mdl_count == 0) begin
          finish_header();
        end
      end
      PH_DATA: begin
        key_byte = mdl_key[(3 - int'(mdl_key_index)) * 8 +: 8];
        data = mdl_flags[0] ? (b ^ key_byte) : b;
        mdl_key_index = mdl_key_index + 2'd1;
        mdl_remaining = mdl_remaining - 64'd1;
        if (mdl_remaining == 0) begin
          mdl_phase = PH_B0;
        end
        expect_result(KIND_PAYLOAD, data, mdl_length, mdl_remaining == 0);
      end
      default: begin
        mdl_opcode = b[3:0];
        mdl_flags = {b[7], b[6:4], 1'b0};
        mdl_length = '0;
        mdl_remaining = '0;
        mdl_key = '0;
        mdl_key_index = '0;
        mdl_count = '0;
        if (b[3] && !b[7]) begin
          mdl_phase = PH_B0;
          expect_result(KIND_ERROR, 8'h00, 64'd0, 1'b0);
        end else begin
          mdl_phase = PH_B1;
        end
      end
    endcase
  endfunction

  task automatic send_stream_byte(input logic [7:0] b);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid   <= 1'b1;
    byte_if.in_byte <= b;
    predict_parse_step(b);
    bytes_sent++;
    do @(posedge clk_i); while (!byte_if.ready);
  endtask

  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic masked, input len_form_e form,
                            input logic [63:0] len, input int unsigned payload_count);
    logic [31:0] key;
    logic [6:0]  code;
    key = $urandom();
    send_stream_byte({fin, rsv, op});
    if (op[3] && !fin) return;
    case (form)
      LEN_EXT16: code = LenCode16;
      LEN_EXT64: code = LenCode64;
      default:   code = len[6:0];
    endcase
    send_stream_byte({masked, code});
    if (form == LEN_EXT16) begin
      send_stream_byte(len[15:8]);
      send_stream_byte(len[7:0]);
    end else if (form == LEN_EXT64) begin
      for (int i = 7; i >= 0; i--) send_stream_byte(len[i * 8 +: 8]);
      if (len[63]) return;
    end
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_stream_byte(key[i * 8 +: 8]);
    end
    for (int unsigned i = 0; i < payload_count; i++) begin
      send_stream_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    logic        fin;
    logic        masked;
    logic [3:0]  op;
    logic [2:0]  rsv;
    logic [63:0] len;
    len_form_e   form;
    fin    = ($urandom_range(0, 4) != 0);
    op     = 4'($urandom_range(0, 15));
    rsv    = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
    masked = ($urandom_range(0, 3) != 0);
    pick   = $urandom_range(0, 99);
    if (pick < 60) begin
      form = LEN_SHORT;
      len  = 64'($urandom_range(0, 12));
    end else if (pick < 80) begin
      form = LEN_SHORT;
      len  = 64'($urandom_range(13, 125));
    end else if (pick < 88) begin
      form = LEN_EXT16;
      len  = 64'($urandom_range(0, 300));
    end else if (pick < 96) begin
      form = LEN_EXT64;
      len  = 64'($urandom_range(0, 40));
    end else begin
      form = LEN_EXT64;
      len  = {$urandom(), $urandom()} | 64'h8000_0000_0000_0000;
    end
    send_frame(fin, rsv, op, masked, form, len, len[63] ? 32'd0 : len[31:0]);
  endtask

  task automatic test_directed_headers();
    send_frame(1'b1, 3'd0, 4'h0, 1'b0, LEN_SHORT, 64'd0, 0);
    send_frame(1'b0, 3'd0, 4'h9, 1'b0, LEN_SHORT, 64'd0, 0);
    send_frame(1'b1, 3'd0, 4'h2, 1'b1, LEN_SHORT, 64'd2, 2);
    send_frame(1'b0, 3'd7, 4'h0, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0000, 0);
    send_frame(1'b1, 3'd5, 4'hF, 1'b0, LEN_EXT16, 64'd1, 1);
  endtask

  task automatic test_random_frames();
    int unsigned stop_at;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  task automatic test_output_backpressure();
    rx_hold_cycles = 300;
    send_frame(1'b1, 3'd0, 4'h2, 1'b1, LEN_SHORT, 64'd100, 100);
  endtask

  task automatic test_streaming_no_idle();
    int unsigned stop_at;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    stop_at = bytes_sent + StreamBytes;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  // The longest legal length never completes, so this frame must come last.
  task automatic test_max_length_frame();
    send_frame(1'b1, 3'd0, 4'h2, 1'b1, LEN_EXT64, 64'h7FFF_FFFF_FFFF_FFFF, 6);
  endtask

  initial begin : rx_ready_gen
    int unsigned stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        stall_left = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result kind", 64'd0, res_if.kind);
      end else begin
        want = expected_results.pop_front();
        if (res_if.kind != want.kind) report_mismatch("kind", want.kind, res_if.kind);
        if (res_if.payload_byte != want.payload_byte)
          report_mismatch("payload_byte", want.payload_byte, res_if.payload_byte);
        if (res_if.opcode != want.opcode)
          report_mismatch("opcode", want.opcode, res_if.opcode);
        if (res_if.final_frame != want.final_frame)
          report_mismatch("final_frame", want.final_frame, res_if.final_frame);
        if (res_if.reserved_bits != want.reserved_bits)
          report_mismatch("reserved_bits", want.reserved_bits, res_if.reserved_bits);
        if (res_if.is_masked != want.is_masked)
          report_mismatch("is_masked", want.is_masked, res_if.is_masked);
        if (res_if.frame_length != want.frame_length)
          report_mismatch("frame_length", want.frame_length, res_if.frame_length);
        if (res_if.frame_end != want.frame_end)
          report_mismatch("frame_end", want.frame_end, res_if.frame_end);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("websocket_frame_parser_tb: FAIL");
      $finish;
    end
  end

  initial begin
    byte_if.valid   = 1'b0;
    byte_if.in_byte = 8'h00;
    rst_ni          = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_headers();
    test_random_frames();
    test_output_backpressure();
    test_streaming_no_idle();
    test_max_length_frame();
    byte_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("websocket_frame_parser_tb: PASS");
    end else begin
      $display("websocket_frame_parser_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
